// ----- hdl/sscpr_pkg.sv -----
// ----------------------------------------------------------------------------
// sscpr_pkg
// Shared types, screen geometry, colours and digit helpers of the clock face
// pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sscpr_pkg;

	localparam int COORD_BITS = 10;
	localparam int EXT_BITS   = COORD_BITS + 1;
	localparam int VAL_BITS   = 7;
	localparam int COLOR_BITS = 16;

	localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(320);
	localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(240);

	localparam logic [COLOR_BITS-1:0] COL_BACK  = 16'h08A3;
	localparam logic [COLOR_BITS-1:0] COL_INSET = 16'h2945;
	localparam logic [COLOR_BITS-1:0] COL_SEG   = 16'hFFFF;
	localparam logic [COLOR_BITS-1:0] COL_COLON = 16'hF800;
	localparam logic [COLOR_BITS-1:0] COL_NONE  = 16'h0000;

	localparam int INSET_MARGIN = 10;
	localparam int DIGIT_Y      = 80;
	localparam int DIGIT_PITCH  = 28;
	localparam int NUM_PAIRS    = 3;
	localparam int NUM_SEGS     = 7;
	localparam int NUM_COLONS   = 2;
	localparam int COLON_Y0     = 110;
	localparam int COLON_Y1     = 128;
	localparam int COLON_SIZE   = 4;

	localparam int PAIR_X [NUM_PAIRS]   = '{40, 128, 216};
	localparam int COLON_X [NUM_COLONS] = '{112, 200};

	// segment order: top, up-left, up-right, middle, lo-left, lo-right, bottom
	localparam int SEG_DX [NUM_SEGS] = '{2, 0, 10, 2, 0, 10, 2};
	localparam int SEG_DY [NUM_SEGS] = '{0, 8, 8, 28, 36, 36, 56};
	localparam int SEG_W  [NUM_SEGS] = '{12, 6, 6, 12, 6, 6, 12};
	localparam int SEG_H  [NUM_SEGS] = '{6, 12, 12, 6, 12, 12, 6};

	// register indexes of the configuration port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [VAL_BITS-1:0]   hours;
		logic [VAL_BITS-1:0]   minutes;
		logic [VAL_BITS-1:0]   seconds;
	} item_t;

	// value / 10 by reciprocal, exact for every 7-bit value
	function automatic logic [3:0] div10(input logic [VAL_BITS-1:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] tens_digit(input logic [VAL_BITS-1:0] v);
		logic [3:0] q;
		q = div10(v);
		if (q >= 4'd10) begin
			q = q - 4'd10;
		end
		return q;
	endfunction

	function automatic logic [3:0] units_digit(input logic [VAL_BITS-1:0] v);
		logic [VAL_BITS-1:0] r;
		r = v - ({3'b000, div10(v)} * 7'd10);
		return r[3:0];
	endfunction

	// bit i set: segment i lit
	function automatic logic [NUM_SEGS-1:0] seg_mask(input logic [3:0] d);
		logic [NUM_SEGS-1:0] m;
		case (d)
			4'd0: m = 7'h77;
			4'd1: m = 7'h24;
			4'd2: m = 7'h5D;
			4'd3: m = 7'h6D;
			4'd4: m = 7'h2E;
			4'd5: m = 7'h6B;
			4'd6: m = 7'h7B;
			4'd7: m = 7'h25;
			4'd8: m = 7'h7F;
			4'd9: m = 7'h6F;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic in_rect(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py, input int x, input int y,
			input int w, input int h);
		logic [EXT_BITS-1:0] ex;
		logic [EXT_BITS-1:0] ey;
		ex = {1'b0, px};
		ey = {1'b0, py};
		return (ex >= EXT_BITS'(x)) && (ex < EXT_BITS'(x + w)) &&
			(ey >= EXT_BITS'(y)) && (ey < EXT_BITS'(y + h));
	endfunction

	function automatic logic digit_hit(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py, input int ox, input logic [3:0] d);
		logic [NUM_SEGS-1:0] m;
		logic hit;
		m = seg_mask(d);
		hit = 1'b0;
		for (int i = 0; i < NUM_SEGS; i++) begin
			if (m[i] && in_rect(px, py, ox + SEG_DX[i], DIGIT_Y + SEG_DY[i],
					SEG_W[i], SEG_H[i])) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/sscpr_cfg.sv -----
// ----------------------------------------------------------------------------
// sscpr_cfg
// Screen size registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module sscpr_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [sscpr_pkg::COORD_BITS-1:0] cfg_data,
	output sscpr_pkg::cfg_t                       cfg
);

	sscpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= sscpr_pkg::WIDTH_RESET;
			cfg_q.height <= sscpr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sscpr_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data;
				sscpr_pkg::REG_HEIGHT: cfg_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/sscpr_shade.sv -----
// ----------------------------------------------------------------------------
// sscpr_shade
// Layer logic for one pixel: background, inset, digits and colon dots.
// ----------------------------------------------------------------------------
`default_nettype none

module sscpr_shade (
	input  wire sscpr_pkg::cfg_t                  cfg,
	input  wire sscpr_pkg::item_t                 item,
	output logic [sscpr_pkg::COLOR_BITS-1:0]      color,
	output logic                                  in_bounds
);

	logic [sscpr_pkg::VAL_BITS-1:0] vals [sscpr_pkg::NUM_PAIRS];
	logic [sscpr_pkg::EXT_BITS-1:0] ex;
	logic [sscpr_pkg::EXT_BITS-1:0] ey;
	logic                           inset;
	logic [sscpr_pkg::NUM_PAIRS-1:0]  seg_hit;
	logic [sscpr_pkg::NUM_COLONS-1:0] dot_hit;

	assign vals[0] = item.hours;
	assign vals[1] = item.minutes;
	assign vals[2] = item.seconds;

	assign ex = {1'b0, item.px};
	assign ey = {1'b0, item.py};

	assign in_bounds = (item.px < cfg.width) && (item.py < cfg.height);

	// empty when the screen is 20 pixels or less in either direction
	assign inset = (ex >= sscpr_pkg::EXT_BITS'(sscpr_pkg::INSET_MARGIN)) &&
		(ex + sscpr_pkg::EXT_BITS'(sscpr_pkg::INSET_MARGIN) < {1'b0, cfg.width}) &&
		(ey >= sscpr_pkg::EXT_BITS'(sscpr_pkg::INSET_MARGIN)) &&
		(ey + sscpr_pkg::EXT_BITS'(sscpr_pkg::INSET_MARGIN) < {1'b0, cfg.height});

	always_comb begin
		for (int p = 0; p < sscpr_pkg::NUM_PAIRS; p++) begin
			seg_hit[p] = sscpr_pkg::digit_hit(item.px, item.py, sscpr_pkg::PAIR_X[p],
					sscpr_pkg::tens_digit(vals[p])) ||
				sscpr_pkg::digit_hit(item.px, item.py,
					sscpr_pkg::PAIR_X[p] + sscpr_pkg::DIGIT_PITCH,
					sscpr_pkg::units_digit(vals[p]));
		end
		for (int i = 0; i < sscpr_pkg::NUM_COLONS; i++) begin
			dot_hit[i] = sscpr_pkg::in_rect(item.px, item.py, sscpr_pkg::COLON_X[i],
					sscpr_pkg::COLON_Y0, sscpr_pkg::COLON_SIZE, sscpr_pkg::COLON_SIZE) ||
				sscpr_pkg::in_rect(item.px, item.py, sscpr_pkg::COLON_X[i],
					sscpr_pkg::COLON_Y1, sscpr_pkg::COLON_SIZE, sscpr_pkg::COLON_SIZE);
		end
	end

	always_comb begin
		if (!in_bounds) begin
			color = sscpr_pkg::COL_NONE;
		end else if (|dot_hit) begin
			color = sscpr_pkg::COL_COLON;
		end else if (|seg_hit) begin
			color = sscpr_pkg::COL_SEG;
		end else if (inset) begin
			color = sscpr_pkg::COL_INSET;
		end else begin
			color = sscpr_pkg::COL_BACK;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/seven_segment_clock_pixel_render.sv -----
// ----------------------------------------------------------------------------
// seven_segment_clock_pixel_render
// Renders one RGB565 pixel of an HH:MM:SS seven-segment clock face per item.
// ----------------------------------------------------------------------------
// usage:
//   s_tdata carries one pixel request: coordinates plus the time to show.
//   m_tdata returns its color, m_tuser flags whether it lies on screen;
//   pixels off screen come back black with m_tuser low.
//   cfg_we / cfg_index / cfg_data set the screen width (index 0) and height
//   (index 1); write them only while no pixel is in flight.
// timing:
//   two register stages (input register, result register): a request is
//   captured in the input register, and its result is registered from
//   there into the result register that drives m_tdata. one pixel per
//   clock is sustained while m_tready stays high; the layer logic between
//   the stages is the only work.
//   arst_n clears both stages and sets the screen to 320 x 240.
// backpressure:
//   when m_tready is low the result holds; the input register still takes
//   one more request, after that s_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_clock_pixel_render (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pixel_x[9:0], pixel_y[19:10], hours[26:20], minutes[33:27],
	// seconds[40:34], zero fill [47:41]
	input  wire logic [47:0]                      s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pixel_color[15:0]
	output logic [15:0]                           m_tdata,
	// in_bounds[0]
	output logic                                  m_tuser,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [sscpr_pkg::COORD_BITS-1:0] cfg_data
);

	localparam int CB = sscpr_pkg::COORD_BITS;
	localparam int VB = sscpr_pkg::VAL_BITS;

	sscpr_pkg::cfg_t  cfg;
	sscpr_pkg::item_t item_s1;
	logic             valid_s1;
	logic             out_free;
	logic [sscpr_pkg::COLOR_BITS-1:0] color;
	logic             in_bounds;
	logic [sscpr_pkg::COLOR_BITS-1:0] color_s2;
	logic             inb_s2;
	logic             valid_s2;

	sscpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.px      <= s_tdata[CB-1:0];
			item_s1.py      <= s_tdata[2*CB-1:CB];
			item_s1.hours   <= s_tdata[2*CB+VB-1:2*CB];
			item_s1.minutes <= s_tdata[2*CB+2*VB-1:2*CB+VB];
			item_s1.seconds <= s_tdata[2*CB+3*VB-1:2*CB+2*VB];
		end
	end

	sscpr_shade u_shade (
		.cfg       (cfg),
		.item      (item_s1),
		.color     (color),
		.in_bounds (in_bounds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			color_s2 <= color;
			inb_s2   <= in_bounds;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = color_s2;
	assign m_tuser  = inb_s2;

`ifndef SYNTHESIS
	// off-screen pixels always come back black
	a_off_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == sscpr_pkg::COL_NONE)
		else $error("off-screen pixel with nonzero color");

	// both stages full and output stalled: no new request may be taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("request taken while pipeline full");

	// an item in the input register moves to the output when it is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_free |=> m_tvalid)
		else $error("item lost between stages");

	// an accepted request always lands in the input register
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request not captured");
`endif

endmodule

`default_nettype wire
